// ===== rtl/wavhp_pkg.sv =====
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADTAG = 3'd1;
  localparam logic [2:0] ST_FORMAT = 3'd2;
  localparam logic [2:0] ST_PCM8   = 3'd3;
  localparam logic [2:0] ST_TRUNC  = 3'd4;
  localparam logic [2:0] ST_SHORT  = 3'd5;

  localparam logic [1:0] CODEC_LINEAR = 2'd0;
  localparam logic [1:0] CODEC_G711A  = 2'd1;
  localparam logic [1:0] CODEC_G711U  = 2'd2;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_ALAW  = 16'd6;
  localparam logic [15:0] FMT_MULAW = 16'd7;

  // Tags as they sit in the shift register after four little-endian bytes
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [31:0] SKIP_FMT6   = 32'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  codec;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] data_size;
  } result_t;

endpackage

// ===== rtl/wav_header_parser.sv =====
// Top level of the WAV header parser: input register, parser core, result register.
//
//   channel | handshake           | word contents
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | data_byte, start_of_file, end_of_file
//   out     | out_valid/out_stall | status, codec, channel_count, rate_hz,
//           |                     | data_size
//
// One byte per cycle sustained while no result is held up by out_stall: a word
// waits in the input register, the parser state is updated from it in a single
// pass and any result is caught in the result register, from which it is offered.
// Reset (rst, synchronous) leaves the parser waiting for a start of file and
// both registers empty.
// A waiting result stalls the parser; the input register still takes one more
// word, after which in_stall follows out_stall.
module wav_header_parser
  import wavhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  codec,
  output logic [15:0] channel_count,
  output logic [31:0] rate_hz,
  output logic [31:0] data_size
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  assign in_item.data_byte     = data_byte;
  assign in_item.start_of_file = start_of_file;
  assign in_item.end_of_file   = end_of_file;

  // Input register: decouples in_stall from the parser for one word
  wavhp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // Parser: tag checks, little-endian field gathering, chunk skipping
  wavhp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (out_valid),
    .res_stall  (out_stall),
    .res        (res)
  );

  assign status        = res.status;
  assign codec         = res.codec;
  assign channel_count = res.channel_count;
  assign rate_hz       = res.rate_hz;
  assign data_size     = res.data_size;

endmodule

// ===== rtl/wavhp_in_stage.sv =====
// Input register: holds one accepted word until the parser takes it.
module wavhp_in_stage
  import wavhp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  logic  full;
  item_t held;

  assign in_stall   = full && !item_take;
  assign item_valid = full;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held <= in_item;
    end
  end

endmodule

// ===== rtl/wavhp_core.sv =====
// Parser state, one-byte step logic and result register.
module wavhp_core
  import wavhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_take,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  typedef enum logic [15:0] {
    PH_IDLE   = 16'h0001,
    PH_RIFF   = 16'h0002,
    PH_FSIZE  = 16'h0004,
    PH_WAVE   = 16'h0008,
    PH_FMT    = 16'h0010,
    PH_FLEN   = 16'h0020,
    PH_FORMAT = 16'h0040,
    PH_CHANS  = 16'h0080,
    PH_RATE   = 16'h0100,
    PH_SKIP6  = 16'h0200,
    PH_BITS   = 16'h0400,
    PH_FREST  = 16'h0800,
    PH_TAG    = 16'h1000,
    PH_CLEN   = 16'h2000,
    PH_CBODY  = 16'h4000,
    PH_DONE   = 16'h8000
  } phase_t;

  phase_t      phase, phase_cur, phase_next;
  logic [1:0]  byte_index, bidx_cur, byte_index_next;
  logic [31:0] field_shift, fs_cur, field_shift_next;
  logic [31:0] skip_count, skip_cur, skip_count_next;
  logic [31:0] fmt_length, clen_cur, fmt_length_next;
  logic [15:0] format_code, fmt_cur, format_code_next;
  logic [15:0] channels_seen, chans_cur, channels_seen_next;
  logic [31:0] rate_seen, rate_cur, rate_seen_next;
  logic        tag_is_data, tdata_cur, tag_is_data_next;
  logic        emit;
  logic [2:0]  emit_status;
  logic [1:0]  emit_codec;
  logic [31:0] emit_len;
  logic        short_field, field_done, skip_phase;
  logic [31:0] shifted;

  assign item_take = item_valid && (!res_valid || !res_stall);

  always_comb begin
    // start of file restarts from a clean state with this very byte
    if (item.start_of_file) begin
      phase_cur = PH_RIFF;
      bidx_cur  = '0;
      fs_cur    = '0;
      skip_cur  = '0;
      clen_cur  = '0;
      fmt_cur   = '0;
      chans_cur = '0;
      rate_cur  = '0;
      tdata_cur = 1'b0;
    end else begin
      phase_cur = phase;
      bidx_cur  = byte_index;
      fs_cur    = field_shift;
      skip_cur  = skip_count;
      clen_cur  = fmt_length;
      fmt_cur   = format_code;
      chans_cur = channels_seen;
      rate_cur  = rate_seen;
      tdata_cur = tag_is_data;
    end

    phase_next         = phase_cur;
    byte_index_next    = bidx_cur;
    field_shift_next   = fs_cur;
    skip_count_next    = skip_cur;
    fmt_length_next    = clen_cur;
    format_code_next   = fmt_cur;
    channels_seen_next = chans_cur;
    rate_seen_next     = rate_cur;
    tag_is_data_next   = tdata_cur;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_codec  = CODEC_LINEAR;
    emit_len    = '0;

    skip_phase  = (phase_cur == PH_SKIP6) || (phase_cur == PH_FREST) ||
                  (phase_cur == PH_CBODY);
    short_field = (phase_cur == PH_FORMAT) || (phase_cur == PH_CHANS) ||
                  (phase_cur == PH_BITS);
    field_done  = short_field ? (bidx_cur == 2'd1) : (bidx_cur == 2'd3);
    shifted     = {item.data_byte, fs_cur[31:8]};

    if (phase_cur != PH_IDLE && phase_cur != PH_DONE) begin
      if (skip_phase) begin
        skip_count_next = skip_cur - 32'd1;
        if (skip_count_next == '0) begin
          phase_next = (phase_cur == PH_SKIP6) ? PH_BITS : PH_TAG;
        end
      end else begin
        field_shift_next = shifted;
        if (!field_done) begin
          byte_index_next = bidx_cur + 2'd1;
        end else begin
          byte_index_next = '0;
          unique case (phase_cur)
            PH_RIFF: begin
              if (shifted != TAG_RIFF) begin
                emit = 1'b1; emit_status = ST_BADTAG;
              end else begin
                phase_next = PH_FSIZE;
              end
            end
            PH_FSIZE: phase_next = PH_WAVE;
            PH_WAVE: begin
              if (shifted != TAG_WAVE) begin
                emit = 1'b1; emit_status = ST_BADTAG;
              end else begin
                phase_next = PH_FMT;
              end
            end
            PH_FMT: begin
              if (shifted != TAG_FMT) begin
                emit = 1'b1; emit_status = ST_BADTAG;
              end else begin
                phase_next = PH_FLEN;
              end
            end
            PH_FLEN: begin
              fmt_length_next = shifted;
              phase_next      = PH_FORMAT;
            end
            PH_FORMAT: begin
              format_code_next = shifted[31:16];
              phase_next       = PH_CHANS;
            end
            PH_CHANS: begin
              channels_seen_next = shifted[31:16];
              phase_next         = PH_RATE;
            end
            PH_RATE: begin
              rate_seen_next  = shifted;
              skip_count_next = SKIP_FMT6;
              phase_next      = PH_SKIP6;
            end
            PH_BITS: begin
              priority if (fmt_cur != FMT_PCM && fmt_cur != FMT_ALAW &&
                           fmt_cur != FMT_MULAW) begin
                emit = 1'b1; emit_status = ST_FORMAT;
              end else if (fmt_cur == FMT_PCM && shifted[31:19] == 13'd1) begin
                emit = 1'b1; emit_status = ST_PCM8;
              end else if (clen_cur < FMT_MIN_LEN) begin
                emit = 1'b1; emit_status = ST_SHORT;
              end else if (clen_cur == FMT_MIN_LEN) begin
                phase_next = PH_TAG;
              end else begin
                skip_count_next = clen_cur - FMT_MIN_LEN;
                phase_next      = PH_FREST;
              end
            end
            PH_TAG: begin
              tag_is_data_next = (shifted == TAG_DATA);
              phase_next       = PH_CLEN;
            end
            PH_CLEN: begin
              priority if (tdata_cur) begin
                emit     = 1'b1;
                emit_len = shifted;
                if (fmt_cur == FMT_ALAW) begin
                  emit_codec = CODEC_G711A;
                end else if (fmt_cur == FMT_MULAW) begin
                  emit_codec = CODEC_G711U;
                end else begin
                  emit_codec = CODEC_LINEAR;
                end
              end else if (shifted == '0) begin
                phase_next = PH_TAG;
              end else begin
                skip_count_next = shifted;
                phase_next      = PH_CBODY;
              end
            end
            default: ;
          endcase
        end
      end

      // end of stream with no result yet: report truncation
      if (!emit && item.end_of_file) begin
        emit        = 1'b1;
        emit_status = ST_TRUNC;
      end
      if (emit) begin
        phase_next = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_index    <= '0;
      field_shift   <= '0;
      skip_count    <= '0;
      fmt_length    <= '0;
      format_code   <= '0;
      channels_seen <= '0;
      rate_seen     <= '0;
      tag_is_data   <= 1'b0;
    end else if (item_take) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      field_shift   <= field_shift_next;
      skip_count    <= skip_count_next;
      fmt_length    <= fmt_length_next;
      format_code   <= format_code_next;
      channels_seen <= channels_seen_next;
      rate_seen     <= rate_seen_next;
      tag_is_data   <= tag_is_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (item_take && emit) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      res.status        <= emit_status;
      res.codec         <= emit_codec;
      res.channel_count <= channels_seen_next;
      res.rate_hz       <= rate_seen_next;
      res.data_size     <= emit_len;
    end
  end

endmodule
